// ----- rtl/core/alm_pkg.sv -----
// alm_pkg: shared sizes, codes and types of the reply line matcher
// no dependencies; imported by every module in rtl/core

package alm_pkg;

  localparam int NUM_RESPONSES = 4;
  localparam int NUM_ERRORS    = 2;
  localparam int LINE_BYTES    = 64;

  localparam int SLOT_COUNT = NUM_RESPONSES + NUM_ERRORS;
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam int LEN_W      = $clog2(LINE_BYTES + 1);
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PAT_DEPTH  = SLOT_COUNT * LINE_BYTES;
  localparam int PAT_AW     = $clog2(PAT_DEPTH);

  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [2:0]  NO_MATCH    = 3'd4;
  localparam logic [24:0] ELAPSED_MAX = 25'h1FF_FFFF;

  typedef enum logic [2:0] {
    MODE_BYTE   = 3'd0,
    MODE_TICK   = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_LOAD   = 3'd3,
    MODE_START  = 3'd4,
    MODE_REPEAT = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_RUNNING = 2'd1,
    ST_REPEAT  = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_RESPONSE = 3'd1,
    EV_ERROR    = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_RESEND   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MATCH
  } top_state_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ISSUE,
    M_CMP
  } match_state_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_res_t;

endpackage

// ----- rtl/core/alm_line_buf.sv -----
// alm_line_buf: received line memory with fill count
// depends on alm_pkg; entries at or past the fill count read as zero

module alm_line_buf import alm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [7:0]       wr_byte,
  input  logic             line_clear,
  input  logic [POS_W-1:0] rd_idx,
  output logic [7:0]       rd_data,
  output logic [LEN_W-1:0] line_len
);

  logic [7:0]       mem [LINE_BYTES];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       rd_q_r;
  logic             rd_ok_r;
  logic             room;

  assign room = (len_r < LEN_W'(LINE_BYTES));

  always_comb begin
    len_nxt = len_r;
    if (wr_en && room) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (line_clear) begin
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[len_r[POS_W-1:0]] <= wr_byte;
    end
    rd_q_r  <= mem[rd_idx];
    rd_ok_r <= (LEN_W'(rd_idx) < len_r);
  end

  assign rd_data  = rd_ok_r ? rd_q_r : 8'h00;
  assign line_len = len_r;

endmodule

// ----- rtl/core/alm_pat_store.sv -----
// alm_pat_store: response and error string memory with clearing sweep
// depends on alm_pkg; sweeps all entries after reset and on request

module alm_pat_store import alm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear_start,
  input  logic              wr_en,
  input  logic [PAT_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [PAT_AW-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output logic              clearing
);

  logic [7:0]        mem [PAT_DEPTH];
  logic              clearing_r, clearing_nxt;
  logic [PAT_AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]        rd_q_r;

  always_comb begin
    clearing_nxt = clearing_r;
    cnt_nxt      = cnt_r;
    if (clearing_r) begin
      if (cnt_r == PAT_AW'(PAT_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
        cnt_nxt      = '0;
      end else begin
        cnt_nxt = cnt_r + PAT_AW'(1);
      end
    end else if (clear_start) begin
      clearing_nxt = 1'b1;
      cnt_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      cnt_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[cnt_r] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data  = rd_q_r;
  assign clearing = clearing_r;

endmodule

// ----- rtl/core/alm_match_seq.sv -----
// alm_match_seq: byte-serial string compare over all pattern slots
// depends on alm_pkg; reads alm_line_buf and alm_pat_store one byte per step

module alm_match_seq import alm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        line_data,
  input  logic [7:0]        pat_data,
  output logic [POS_W-1:0]  line_idx,
  output logic [PAT_AW-1:0] pat_addr,
  output match_res_t        res
);

  match_state_t      state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PAT_AW-1:0] base_r, base_nxt;
  logic              done_r, done_nxt;
  logic              hit_r, hit_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    done_nxt  = 1'b0;
    hit_nxt   = hit_r;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          slot_nxt  = '0;
          pos_nxt   = '0;
          base_nxt  = '0;
          state_nxt = M_ISSUE;
        end
      end
      M_ISSUE: begin
        state_nxt = M_CMP;
      end
      M_CMP: begin
        priority if (line_data != pat_data) begin
          if (slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
            done_nxt  = 1'b1;
            hit_nxt   = 1'b0;
            state_nxt = M_IDLE;
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            base_nxt  = base_r + PAT_AW'(LINE_BYTES);
            pos_nxt   = '0;
            state_nxt = M_ISSUE;
          end
        end else if (line_data == 8'h00 || pos_r == POS_W'(LINE_BYTES - 1)) begin
          done_nxt  = 1'b1;
          hit_nxt   = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = M_ISSUE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    pos_r  <= pos_nxt;
    base_r <= base_nxt;
    hit_r  <= hit_nxt;
  end

  assign line_idx = pos_r;
  assign pat_addr = base_r + PAT_AW'(pos_r);
  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.slot = slot_r;

endmodule

// ----- rtl/core/at_response_line_matcher.sv -----
// at_response_line_matcher: top level, command state, tick timer and result register
// depends on alm_pkg, alm_line_buf, alm_pat_store and alm_match_seq
//
// channel   direction  transfer content
// in_*      slave      one input item: mode in tuser, other fields in tdata
// out_*     master     one result item per input item: event in tuser
//
// for most items the result is in the output register the next cycle
// a finished line while a command runs is compared against the slots in order through one
// byte comparator, each byte taking an issue step and a compare step, until a slot matches
// or all slots fail; the result is loaded into the output register when the compare ends
// the pattern memory is swept entry by entry after reset and after a
// clear item; no item is taken meanwhile
// ready is low while the output register holds a result that is not taken

module at_response_line_matcher import alm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rx_byte[7:0], pattern_slot[10:8], pattern_pos[16:11], tick_count[32:17],
  // timeout_limit_in[56:33], critical_in[57], command_tag_in[65:58], zero[71:66]
  input  logic [71:0] in_tdata,
  // mode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // match_index[2:0], critical_out[3], busy_res[4], status[6:5],
  // command_tag_out[14:7], zero[15]
  output logic [15:0] out_tdata,
  // event_res[2:0]
  output logic [2:0]  out_tuser
);

  top_state_t  state_r, state_nxt;
  status_t     status_r, status_nxt;
  logic        busy_r, busy_nxt;
  logic        crit_r, crit_nxt;
  logic [24:0] elapsed_r, elapsed_nxt;
  logic [23:0] limit_r, limit_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  prev_r, prev_nxt;

  logic        out_valid_r, out_valid_nxt;
  event_t      out_ev_r, out_ev_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_crit_r, out_crit_nxt;
  logic        out_busy_r, out_busy_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [7:0]  out_tag_r, out_tag_nxt;

  mode_t       mode;
  logic [7:0]  rx_byte;
  logic [2:0]  in_slot;
  logic [5:0]  in_pos;
  logic [15:0] in_ticks;
  logic [23:0] in_limit;
  logic        in_crit;
  logic [7:0]  in_tag;

  logic        accept;
  logic        load_out;
  event_t      ev;
  logic [2:0]  idx;
  logic [25:0] tick_sum;
  logic [24:0] tick_sat;

  logic              line_wr_en;
  logic              line_clear;
  logic [POS_W-1:0]  line_idx;
  logic [7:0]        line_data;
  logic [LEN_W-1:0]  line_len;
  logic              pat_clear;
  logic              pat_wr_en;
  logic [PAT_AW-1:0] pat_wr_addr;
  logic [PAT_AW-1:0] pat_rd_addr;
  logic [7:0]        pat_data;
  logic              pat_clearing;
  logic              match_start;
  match_res_t        match_res;

  assign mode     = mode_t'(in_tuser);
  assign rx_byte  = in_tdata[7:0];
  assign in_slot  = in_tdata[10:8];
  assign in_pos   = in_tdata[16:11];
  assign in_ticks = in_tdata[32:17];
  assign in_limit = in_tdata[56:33];
  assign in_crit  = in_tdata[57];
  assign in_tag   = in_tdata[65:58];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign tick_sum    = {1'b0, elapsed_r} + 26'(in_ticks);
  assign tick_sat    = tick_sum[25] ? ELAPSED_MAX : tick_sum[24:0];
  assign pat_wr_addr = PAT_AW'(int'(in_slot) * LINE_BYTES + int'(in_pos));

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    busy_nxt    = busy_r;
    crit_nxt    = crit_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    tag_nxt     = tag_r;
    prev_nxt    = prev_r;
    load_out    = 1'b0;
    ev          = EV_NONE;
    idx         = NO_MATCH;
    line_wr_en  = 1'b0;
    line_clear  = 1'b0;
    pat_clear   = 1'b0;
    pat_wr_en   = 1'b0;
    match_start = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (!pat_clearing) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (mode)
            MODE_BYTE: begin
              line_wr_en = 1'b1;
              prev_nxt   = rx_byte;
              if (prev_r == CHAR_CR && rx_byte == CHAR_LF) begin
                if (status_r == ST_RUNNING || status_r == ST_REPEAT) begin
                  match_start = 1'b1;
                  load_out    = 1'b0;
                  state_nxt   = S_MATCH;
                end else begin
                  line_clear = 1'b1;
                end
              end
            end
            MODE_TICK: begin
              elapsed_nxt = tick_sat;
              if (status_r == ST_RUNNING) begin
                if ({1'b0, limit_r} <= tick_sat) begin
                  elapsed_nxt = '0;
                  status_nxt  = ST_FAILED;
                  busy_nxt    = crit_r;
                  ev          = EV_TIMEOUT;
                end
              end else if (status_r == ST_REPEAT) begin
                status_nxt = ST_RUNNING;
                ev         = EV_RESEND;
              end
            end
            MODE_CLEAR: begin
              pat_clear = 1'b1;
              state_nxt = S_CLEAR;
            end
            MODE_LOAD: begin
              pat_wr_en = (int'(in_slot) < SLOT_COUNT) && (int'(in_pos) < LINE_BYTES);
            end
            MODE_START: begin
              elapsed_nxt = '0;
              limit_nxt   = in_limit;
              crit_nxt    = in_crit;
              tag_nxt     = in_tag;
              status_nxt  = ST_RUNNING;
              busy_nxt    = 1'b1;
            end
            MODE_REPEAT: begin
              status_nxt = ST_REPEAT;
            end
            default: ;
          endcase
        end
      end
      S_MATCH: begin
        if (match_res.done) begin
          line_clear = 1'b1;
          load_out   = 1'b1;
          state_nxt  = S_IDLE;
          if (match_res.hit) begin
            if (int'(match_res.slot) < NUM_RESPONSES) begin
              busy_nxt   = 1'b0;
              status_nxt = ST_SUCCESS;
              ev         = EV_RESPONSE;
              idx        = 3'(match_res.slot);
            end else begin
              ev  = EV_ERROR;
              idx = 3'(int'(match_res.slot) - NUM_RESPONSES);
              if (crit_r) begin
                busy_nxt   = 1'b1;
                status_nxt = ST_REPEAT;
              end else begin
                busy_nxt   = 1'b0;
                status_nxt = ST_FAILED;
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_ev_nxt     = out_ev_r;
    out_idx_nxt    = out_idx_r;
    out_crit_nxt   = out_crit_r;
    out_busy_nxt   = out_busy_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_ev_nxt     = ev;
      out_idx_nxt    = idx;
      out_crit_nxt   = crit_nxt;
      out_busy_nxt   = busy_nxt;
      out_status_nxt = status_nxt;
      out_tag_nxt    = tag_nxt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      status_r    <= ST_FAILED;
      busy_r      <= 1'b0;
      crit_r      <= 1'b0;
      elapsed_r   <= '0;
      limit_r     <= '0;
      tag_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      busy_r      <= busy_nxt;
      crit_r      <= crit_nxt;
      elapsed_r   <= elapsed_nxt;
      limit_r     <= limit_nxt;
      tag_r       <= tag_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r     <= out_ev_nxt;
    out_idx_r    <= out_idx_nxt;
    out_crit_r   <= out_crit_nxt;
    out_busy_r   <= out_busy_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {1'b0, out_tag_r, out_status_r, out_busy_r, out_crit_r, out_idx_r};

  alm_line_buf u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (line_wr_en),
    .wr_byte    (rx_byte),
    .line_clear (line_clear),
    .rd_idx     (line_idx),
    .rd_data    (line_data),
    .line_len   (line_len)
  );

  alm_pat_store u_pat_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_start (pat_clear),
    .wr_en       (pat_wr_en),
    .wr_addr     (pat_wr_addr),
    .wr_data     (rx_byte),
    .rd_addr     (pat_rd_addr),
    .rd_data     (pat_data),
    .clearing    (pat_clearing)
  );

  alm_match_seq u_match_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (match_start),
    .line_data (line_data),
    .pat_data  (pat_data),
    .line_idx  (line_idx),
    .pat_addr  (pat_rd_addr),
    .res       (match_res)
  );

  a_done_in_match: assert property (@(posedge clk) disable iff (!rst_n)
    match_res.done |-> state_r == S_MATCH)
    else $error("compare finished outside of a line match");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    pat_clearing |-> !in_tready)
    else $error("input ready during pattern sweep");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == MODE_START) |=> (status_r == ST_RUNNING) && busy_r)
    else $error("start transfer did not begin a command");

  a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
    line_len <= LEN_W'(LINE_BYTES))
    else $error("line fill count past capacity");

  a_resp_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r == EV_RESPONSE) |-> (out_status_r == ST_SUCCESS) && !out_busy_r)
    else $error("response match without success status");

endmodule
